// File: hdl/modular_exponentiation_macros.svh
// Assertion macros shared by the modular exponentiation RTL
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH
`ifndef SYNTH
`define MEXP_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define MEXP_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MEXP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MEXP_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define MEXP_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define MEXP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: hdl/mexp_pkg.sv
// Shared types for the modular exponentiation block
`default_nettype none
package mexp_pkg;
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_WAIT,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

// File: hdl/mexp_cell.sv
// One cell of the modular multiplier chain: one multiplier bit per cell
`default_nettype none
module mexp_cell #(
   parameter int OPERAND_BITS = 31
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    valid_i,
   input  wire logic [OPERAND_BITS-1:0] ra_i,
   input  wire logic [OPERAND_BITS-1:0] rs_i,
   input  wire logic [OPERAND_BITS-1:0] a_i,
   input  wire logic [OPERAND_BITS-1:0] m_i,
   input  wire logic [OPERAND_BITS-1:0] ba_i,
   input  wire logic [OPERAND_BITS-1:0] bs_i,
   output logic                         valid_o,
   output logic [OPERAND_BITS-1:0]      ra_o,
   output logic [OPERAND_BITS-1:0]      rs_o,
   output logic [OPERAND_BITS-1:0]      a_o,
   output logic [OPERAND_BITS-1:0]      m_o,
   output logic [OPERAND_BITS-1:0]      ba_o,
   output logic [OPERAND_BITS-1:0]      bs_o
);
   localparam int N = OPERAND_BITS;

   // double, reduce, conditionally add the multiplicand, reduce
   function automatic logic [N-1:0] mod_step(input logic [N-1:0] r, input logic take,
                                             input logic [N-1:0] a, input logic [N-1:0] m);
      logic [N:0] d;
      d = {r, 1'b0};
      if (d >= {1'b0, m}) begin
         d = d - {1'b0, m};
      end
      if (take) begin
         d = d + {1'b0, a};
         if (d >= {1'b0, m}) begin
            d = d - {1'b0, m};
         end
      end
      return d[N-1:0];
   endfunction

   logic         valid_ff;
   logic [N-1:0] ra_ff, rs_ff, a_ff, m_ff, ba_ff, bs_ff;
   logic [N-1:0] ra_in, rs_in, ba_in, bs_in;

   always_comb begin
      ra_in = mod_step(ra_i, ba_i[N-1], a_i, m_i);
      rs_in = mod_step(rs_i, bs_i[N-1], a_i, m_i);
      ba_in = {ba_i[N-2:0], 1'b0};
      bs_in = {bs_i[N-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      ra_ff <= ra_in;
      rs_ff <= rs_in;
      a_ff  <= a_i;
      m_ff  <= m_i;
      ba_ff <= ba_in;
      bs_ff <= bs_in;
   end

   assign valid_o = valid_ff;
   assign ra_o    = ra_ff;
   assign rs_o    = rs_ff;
   assign a_o     = a_ff;
   assign m_o     = m_ff;
   assign ba_o    = ba_ff;
   assign bs_o    = bs_ff;
endmodule
`default_nettype wire

// File: hdl/mexp_chain.sv
// Row of multiplier cells computing two modular products side by side
`default_nettype none
module mexp_chain #(
   parameter int OPERAND_BITS = 31
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire logic [OPERAND_BITS-1:0] in_a,
   input  wire logic [OPERAND_BITS-1:0] in_m,
   input  wire logic [OPERAND_BITS-1:0] in_ba,
   input  wire logic [OPERAND_BITS-1:0] in_bs,
   output logic                         out_valid,
   output logic [OPERAND_BITS-1:0]      out_ra,
   output logic [OPERAND_BITS-1:0]      out_rs
);
   localparam int N = OPERAND_BITS;

   logic         valid_w [N+1];
   logic [N-1:0] ra_w [N+1];
   logic [N-1:0] rs_w [N+1];
   logic [N-1:0] a_w  [N+1];
   logic [N-1:0] m_w  [N+1];
   logic [N-1:0] ba_w [N+1];
   logic [N-1:0] bs_w [N+1];

   assign valid_w[0] = in_valid;
   assign ra_w[0]    = '0;
   assign rs_w[0]    = '0;
   assign a_w[0]     = in_a;
   assign m_w[0]     = in_m;
   assign ba_w[0]    = in_ba;
   assign bs_w[0]    = in_bs;

   for (genvar k = 0; k < N; k++) begin : g_cell
      mexp_cell #(.OPERAND_BITS(N)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (valid_w[k]),
         .ra_i    (ra_w[k]),
         .rs_i    (rs_w[k]),
         .a_i     (a_w[k]),
         .m_i     (m_w[k]),
         .ba_i    (ba_w[k]),
         .bs_i    (bs_w[k]),
         .valid_o (valid_w[k+1]),
         .ra_o    (ra_w[k+1]),
         .rs_o    (rs_w[k+1]),
         .a_o     (a_w[k+1]),
         .m_o     (m_w[k+1]),
         .ba_o    (ba_w[k+1]),
         .bs_o    (bs_w[k+1])
      );
   end

   assign out_valid = valid_w[N];
   assign out_ra    = ra_w[N];
   assign out_rs    = rs_w[N];
endmodule
`default_nettype wire

// File: hdl/modular_exponentiation.sv
// Top level: right-to-left square-and-multiply modular exponentiation
// Passes: one pass through the cell chain reduces the base, then one pass per
// exponent bit up to the highest set bit.
// Throughput: one transaction at a time, set by the length of the cell chain.
// Reset: synchronous, active high; clears the sequencer, the response valid and the chain valid bits.
`default_nettype none
`include "modular_exponentiation_macros.svh"
module modular_exponentiation #(
   parameter int OPERAND_BITS = 31
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // fields from bit 0: base, exponent, modulus, zero padding
   input  wire logic [((3*OPERAND_BITS+7)/8)*8-1:0]    req_tdata,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // fields from bit 0: result, zero padding
   output logic [((OPERAND_BITS+7)/8)*8-1:0]           rsp_tdata
);
   localparam int N     = OPERAND_BITS;
   localparam int RSP_W = ((OPERAND_BITS+7)/8)*8;

   mexp_pkg::state_type state_ff, state_in;

   logic [N-1:0] base_ff, exp_ff, mod_ff, acc_ff, pow_ff, res_ff;
   logic [N-1:0] base_in, exp_in, mod_in, acc_in, pow_in, res_in;
   logic         first_ff, first_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [N-1:0] rsp_data_ff, rsp_data_in;

   logic [N-1:0] req_base, req_exp, req_mod;
   logic         req_fire, rsp_free, last_pass;
   logic         in_wait, rsp_stall;
   logic         chain_in_valid, chain_out_valid;
   logic [N-1:0] chain_a, chain_ba, chain_bs, chain_ra, chain_rs, unit;

   assign req_base = req_tdata[N-1:0];
   assign req_exp  = req_tdata[2*N-1:N];
   assign req_mod  = req_tdata[3*N-1:2*N];

   assign req_tready = (state_ff == mexp_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   // exponent runs out after this pass
   assign last_pass  = (exp_ff[N-1:1] == '0);

   // one reduced to the modulus: zero when the modulus is one
   assign unit = {{(N-1){1'b0}}, (mod_ff != {{(N-1){1'b0}}, 1'b1})};

   // first pass folds the base below the modulus; later passes square the power
   // in one lane and multiply it into the accumulator in the other
   assign chain_in_valid = (state_ff == mexp_pkg::ST_LAUNCH);
   assign chain_a        = first_ff ? unit : pow_ff;
   assign chain_ba       = acc_ff;
   assign chain_bs       = first_ff ? base_ff : pow_ff;

   mexp_chain #(.OPERAND_BITS(N)) u_chain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_in_valid),
      .in_a      (chain_a),
      .in_m      (mod_ff),
      .in_ba     (chain_ba),
      .in_bs     (chain_bs),
      .out_valid (chain_out_valid),
      .out_ra    (chain_ra),
      .out_rs    (chain_rs)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (req_fire) begin
               if ((req_mod == '0) || (req_exp == '0)) begin
                  state_in = mexp_pkg::ST_DONE;
               end else begin
                  state_in = mexp_pkg::ST_LAUNCH;
               end
            end
         end
         mexp_pkg::ST_LAUNCH: begin
            state_in = mexp_pkg::ST_WAIT;
         end
         mexp_pkg::ST_WAIT: begin
            if (chain_out_valid) begin
               if (!first_ff && last_pass) begin
                  state_in = mexp_pkg::ST_DONE;
               end else begin
                  state_in = mexp_pkg::ST_LAUNCH;
               end
            end
         end
         mexp_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = mexp_pkg::ST_IDLE;
            end
         end
         default: state_in = mexp_pkg::ST_IDLE;
      endcase
   end

   // datapath and output register
   always_comb begin
      base_in      = base_ff;
      exp_in       = exp_ff;
      mod_in       = mod_ff;
      acc_in       = acc_ff;
      pow_in       = pow_ff;
      res_in       = res_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (req_fire) begin
               base_in  = req_base;
               exp_in   = req_exp;
               mod_in   = req_mod;
               acc_in   = {{(N-1){1'b0}}, 1'b1};
               first_in = 1'b1;
               // early answers: zero modulus gives 0, zero exponent gives 1
               res_in   = {{(N-1){1'b0}}, (req_mod != '0)};
            end
         end
         mexp_pkg::ST_WAIT: begin
            if (chain_out_valid) begin
               pow_in   = chain_rs;
               first_in = 1'b0;
               if (!first_ff) begin
                  if (exp_ff[0]) begin
                     acc_in = chain_ra;
                  end
                  exp_in = {1'b0, exp_ff[N-1:1]};
                  res_in = exp_ff[0] ? chain_ra : acc_ff;
               end
            end
         end
         mexp_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mexp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      mod_ff      <= mod_in;
      acc_ff      <= acc_in;
      pow_ff      <= pow_in;
      res_ff      <= res_in;
      first_ff    <= first_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-N){1'b0}}, rsp_data_ff};

   // checks
   assign in_wait   = (state_ff == mexp_pkg::ST_WAIT);
   assign rsp_stall = rsp_valid_ff && !rsp_tready;
   `MEXP_ASSERT_IMPLIES(a_chain_only_in_wait, clock, reset, chain_out_valid, in_wait)
   `MEXP_ASSERT_IMPLIES(a_residue_below_mod, clock, reset, chain_out_valid, chain_rs < mod_ff)
   `MEXP_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_fire, !req_tready)
   `MEXP_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
endmodule
`default_nettype wire
